// ----- src/dlsog_pkg.sv -----
// Shared types and constants for the dual load switch overcurrent guard.
`default_nettype none
package dlsog_pkg;

  localparam int SENSE_W   = 12;
  localparam int ELAPSED_W = 16;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_THRESHOLD   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_SAMPLES     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_INTERVAL = 8'd3;

  localparam logic [ELAPSED_W-1:0] RST_SAMPLE_INTERVAL  = 16'd10;
  localparam logic [SENSE_W-1:0]   RST_TRIP_THRESHOLD   = 12'd3000;
  localparam logic [COUNT_W-1:0]   RST_TRIP_SAMPLES     = 8'd3;
  localparam logic [ELAPSED_W-1:0] RST_RECOVER_INTERVAL = 16'd1000;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

  typedef struct packed {
    logic [SENSE_W-1:0]   trip_threshold;
    logic [COUNT_W-1:0]   trip_samples;
    logic [ELAPSED_W-1:0] recover_interval;
  } chan_cfg_t;

  typedef struct packed {
    logic               left_gate;
    logic               right_gate;
    logic               left_fault;
    logic               right_fault;
    logic               sampled;
    logic [SENSE_W-1:0] left_level;
    logic [SENSE_W-1:0] right_level;
  } result_t;

endpackage
`default_nettype wire

// ----- src/dlsog_chan.sv -----
// One channel: overcurrent count, trip flag, recovery timer and last reading.
`default_nettype none
module dlsog_chan (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic                        sample_now,
  input  wire logic [dlsog_pkg::SENSE_W-1:0] level,
  input  wire dlsog_pkg::chan_cfg_t        cfg,
  output logic                             trip_next,
  output logic [dlsog_pkg::SENSE_W-1:0]    last_next
);
  import dlsog_pkg::*;

  logic [COUNT_W-1:0]   over_count, over_count_next, count_inc;
  logic                 trip_flag;
  logic                 recover_armed, recover_armed_next;
  logic [ELAPSED_W-1:0] recover_elapsed, recover_elapsed_next, elapsed_inc;
  logic [SENSE_W-1:0]   last_sample;

  always_comb begin
    elapsed_inc = recover_elapsed;
    if (recover_armed && recover_elapsed != ELAPSED_MAX) begin
      elapsed_inc = recover_elapsed + 1'b1;
    end
    count_inc = (over_count != COUNT_MAX) ? over_count + 1'b1 : over_count;

    over_count_next      = over_count;
    trip_next            = trip_flag;
    recover_armed_next   = recover_armed;
    recover_elapsed_next = elapsed_inc;
    last_next            = last_sample;

    if (sample_now) begin
      last_next = level;
      if (level >= cfg.trip_threshold) begin
        if (!trip_flag) begin
          if (count_inc >= cfg.trip_samples) begin
            trip_next            = 1'b1;
            over_count_next      = '0;
            recover_armed_next   = 1'b0;
            recover_elapsed_next = '0;
          end else begin
            over_count_next = count_inc;
          end
        end
      end else begin
        over_count_next = '0;
        if (trip_flag) begin
          if (!recover_armed) begin
            recover_armed_next   = 1'b1;
            recover_elapsed_next = '0;
          end else if (elapsed_inc >= cfg.recover_interval) begin
            trip_next            = 1'b0;
            recover_armed_next   = 1'b0;
            recover_elapsed_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_count      <= '0;
      trip_flag       <= 1'b0;
      recover_armed   <= 1'b0;
      recover_elapsed <= '0;
      last_sample     <= '0;
    end else if (step) begin
      over_count      <= over_count_next;
      trip_flag       <= trip_next;
      recover_armed   <= recover_armed_next;
      recover_elapsed <= recover_elapsed_next;
      last_sample     <= last_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/dlsog_out.sv -----
// Result register with backpressure toward the master-side stream.
`default_nettype none
module dlsog_out (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               load,
  input  wire dlsog_pkg::result_t                 result,
  output logic                                    ready,
  output logic                                    tvalid,
  input  wire logic                               tready,
  output logic [dlsog_pkg::OUT_DATA_W-1:0]        tdata
);
  import dlsog_pkg::*;

  result_t held;

  assign ready = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign tdata = {3'b000, held.right_level, held.left_level, held.sampled,
                  held.right_fault, held.left_fault, held.right_gate, held.left_gate};

endmodule
`default_nettype wire

// ----- src/dual_load_switch_overcurrent_guard.sv -----
// Top level of the dual load switch overcurrent guard.
//
// Each slave-side beat is one millisecond tick carrying both current-sense
// readings and both switch requests. Each tick yields exactly one master-side
// beat with the gate drives, fault flags, a sampled flag and the last
// sampled readings.
// Latency: the result beat is valid on the cycle after the tick is accepted.
// Throughput: one tick per clock while m_axis_tready is high; channel state
// and sample timer update on acceptance; the result lands in one register.
// Stall: when the receiver holds m_axis_tready low, the result register holds
// its beat and s_axis_tready drops until that beat is taken, so no beat is
// lost or repeated.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one register
// per beat; index 0 sample interval, 1 trip threshold, 2 trip samples,
// 3 recovery interval; other indexes are dropped. Write only while idle.
// Reset: rst (synchronous, active high) restores register defaults
// 10/3000/3/1000, clears all timers, counts, trips and readings, and empties
// the result register.
`default_nettype none
module dual_load_switch_overcurrent_guard (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // left_sample[11:0], right_sample[23:12], left_request[24],
  // right_request[25], zero [31:26]
  input  wire logic [dlsog_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // left_gate[0], right_gate[1], left_fault[2], right_fault[3], sampled[4],
  // left_level[16:5], right_level[28:17], zero [31:29]
  output logic [dlsog_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dlsog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dlsog_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import dlsog_pkg::*;

  logic                 accept;
  logic [SENSE_W-1:0]   left_sample, right_sample;
  logic                 left_request, right_request;
  logic [ELAPSED_W-1:0] sample_interval;
  chan_cfg_t            chan_cfg;
  logic                 sample_armed, sample_armed_next;
  logic [ELAPSED_W-1:0] sample_elapsed, sample_elapsed_next, sample_inc;
  logic                 sample_now;
  logic                 left_trip, right_trip, any_trip;
  logic [SENSE_W-1:0]   left_last, right_last;
  result_t              result;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign left_sample   = s_axis_tdata[SENSE_W-1:0];
  assign right_sample  = s_axis_tdata[2*SENSE_W-1:SENSE_W];
  assign left_request  = s_axis_tdata[2*SENSE_W];
  assign right_request = s_axis_tdata[2*SENSE_W+1];
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval           <= RST_SAMPLE_INTERVAL;
      chan_cfg.trip_threshold   <= RST_TRIP_THRESHOLD;
      chan_cfg.trip_samples     <= RST_TRIP_SAMPLES;
      chan_cfg.recover_interval <= RST_RECOVER_INTERVAL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_INTERVAL:  sample_interval           <= cfg_data;
        CFG_TRIP_THRESHOLD:   chan_cfg.trip_threshold   <= cfg_data[SENSE_W-1:0];
        CFG_TRIP_SAMPLES:     chan_cfg.trip_samples     <= cfg_data[COUNT_W-1:0];
        CFG_RECOVER_INTERVAL: chan_cfg.recover_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sample_inc = (sample_elapsed != ELAPSED_MAX) ? sample_elapsed + 1'b1 : sample_elapsed;
    sample_now          = 1'b0;
    sample_armed_next   = 1'b1;
    sample_elapsed_next = '0;
    if (sample_armed) begin
      if (sample_inc >= sample_interval) begin
        sample_now        = 1'b1;
        sample_armed_next = 1'b0;
      end else begin
        sample_elapsed_next = sample_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_armed   <= 1'b0;
      sample_elapsed <= '0;
    end else if (accept) begin
      sample_armed   <= sample_armed_next;
      sample_elapsed <= sample_elapsed_next;
    end
  end

  dlsog_chan u_left (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .sample_now (sample_now),
    .level      (left_sample),
    .cfg        (chan_cfg),
    .trip_next  (left_trip),
    .last_next  (left_last)
  );

  dlsog_chan u_right (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .sample_now (sample_now),
    .level      (right_sample),
    .cfg        (chan_cfg),
    .trip_next  (right_trip),
    .last_next  (right_last)
  );

  assign any_trip = left_trip || right_trip;

  always_comb begin
    result.left_gate   = left_request && !any_trip;
    result.right_gate  = right_request && !any_trip;
    result.left_fault  = left_trip;
    result.right_fault = right_trip;
    result.sampled     = sample_now;
    result.left_level  = left_last;
    result.right_level = right_last;
  end

  dlsog_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .ready  (s_axis_tready),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- tb/tb_dual_load_switch_overcurrent_guard.sv -----
// Self-checking testbench for the dual load switch overcurrent guard.
module tb_dual_load_switch_overcurrent_guard;
  timeunit 1ns;
  timeprecision 1ps;

  import dlsog_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'hFC;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 60;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic               left_gate;
    logic               right_gate;
    logic               left_fault;
    logic               right_fault;
    logic               sampled;
    logic [SENSE_W-1:0] left_level;
    logic [SENSE_W-1:0] right_level;
  } guard_out_t;

  class overcurrent_scoreboard;
    logic [ELAPSED_W-1:0] interval;
    logic [SENSE_W-1:0]   threshold;
    logic [COUNT_W-1:0]   need;
    logic [ELAPSED_W-1:0] recover;
    bit                   armed;
    logic [ELAPSED_W-1:0] elapsed;
    logic [COUNT_W-1:0]   over [2];
    bit                   tripped [2];
    bit                   rec_armed [2];
    logic [ELAPSED_W-1:0] rec_elapsed [2];
    logic [SENSE_W-1:0]   level [2];
    guard_out_t           expected_q [$];
    int errors, beats, ticks, samples, trips, clears, writes;

    function new();
      errors = 0;
      beats = 0;
      ticks = 0;
      samples = 0;
      trips = 0;
      clears = 0;
      writes = 0;
      interval = RST_SAMPLE_INTERVAL;
      threshold = RST_TRIP_THRESHOLD;
      need = RST_TRIP_SAMPLES;
      recover = RST_RECOVER_INTERVAL;
      armed = 0;
      elapsed = '0;
      for (int c = 0; c < 2; c++) begin
        over[c] = '0;
        tripped[c] = 0;
        rec_armed[c] = 0;
        rec_elapsed[c] = '0;
        level[c] = '0;
      end
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      writes++;
      case (idx)
        CFG_SAMPLE_INTERVAL:  interval = val;
        CFG_TRIP_THRESHOLD:   threshold = val[SENSE_W-1:0];
        CFG_TRIP_SAMPLES:     need = val[COUNT_W-1:0];
        CFG_RECOVER_INTERVAL: recover = val;
        default: ;
      endcase
    endfunction

    function logic [ELAPSED_W-1:0] bump(logic [ELAPSED_W-1:0] v);
      return (v == ELAPSED_MAX) ? v : v + 1'b1;
    endfunction

    function void take_sample(int c, logic [SENSE_W-1:0] lvl);
      level[c] = lvl;
      if (lvl >= threshold) begin
        if (!tripped[c]) begin
          if (over[c] != COUNT_MAX) over[c] = over[c] + 1'b1;
          if (over[c] >= need) begin
            tripped[c] = 1;
            over[c] = '0;
            rec_armed[c] = 0;
            rec_elapsed[c] = '0;
            trips++;
          end
        end
      end else begin
        over[c] = '0;
        if (tripped[c]) begin
          if (!rec_armed[c]) begin
            rec_armed[c] = 1;
            rec_elapsed[c] = '0;
          end else if (rec_elapsed[c] >= recover) begin
            tripped[c] = 0;
            rec_armed[c] = 0;
            rec_elapsed[c] = '0;
            clears++;
          end
        end
      end
    endfunction

    function void note_tick(logic [IN_DATA_W-1:0] d);
      guard_out_t o;
      bit any_trip;
      ticks++;
      for (int c = 0; c < 2; c++)
        if (rec_armed[c]) rec_elapsed[c] = bump(rec_elapsed[c]);
      o.sampled = 0;
      if (!armed) begin
        armed = 1;
        elapsed = '0;
      end else begin
        elapsed = bump(elapsed);
        if (elapsed >= interval) begin
          armed = 0;
          elapsed = '0;
          o.sampled = 1;
          samples++;
          take_sample(0, d[SENSE_W-1:0]);
          take_sample(1, d[2*SENSE_W-1:SENSE_W]);
        end
      end
      any_trip = tripped[0] || tripped[1];
      o.left_gate = d[2*SENSE_W] && !any_trip;
      o.right_gate = d[2*SENSE_W+1] && !any_trip;
      o.left_fault = tripped[0];
      o.right_fault = tripped[1];
      o.left_level = level[0];
      o.right_level = level[1];
      expected_q.push_back(o);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      if (errors < PRINT_LIMIT)
        $display("mismatch at result %0d: %s want %h got %h", beats, what, want, got);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      guard_out_t want;
      beats++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", '0, d[15:0]);
        return;
      end
      want = expected_q.pop_front();
      if (d[0] !== want.left_gate)
        report_mismatch("left_gate", 16'(want.left_gate), 16'(d[0]));
      if (d[1] !== want.right_gate)
        report_mismatch("right_gate", 16'(want.right_gate), 16'(d[1]));
      if (d[2] !== want.left_fault)
        report_mismatch("left_fault", 16'(want.left_fault), 16'(d[2]));
      if (d[3] !== want.right_fault)
        report_mismatch("right_fault", 16'(want.right_fault), 16'(d[3]));
      if (d[4] !== want.sampled)
        report_mismatch("sampled", 16'(want.sampled), 16'(d[4]));
      if (d[16:5] !== want.left_level)
        report_mismatch("left_level", 16'(want.left_level), 16'(d[16:5]));
      if (d[28:17] !== want.right_level)
        report_mismatch("right_level", 16'(want.right_level), 16'(d[28:17]));
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  overcurrent_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_off_req = 0;
  int flood = 0;
  int settings = 0;
  int quiet = 0;
  logic [SENSE_W-1:0]   cur_th = RST_TRIP_THRESHOLD;
  logic [ELAPSED_W-1:0] cur_iv = RST_SAMPLE_INTERVAL;

  dual_load_switch_overcurrent_guard u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("dual_load_switch_overcurrent_guard regression: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return (no_idle || flood > 0) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [SENSE_W-1:0] draw_level(bit hi, logic [SENSE_W-1:0] th);
    if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, 4095));
    if (hi || th == 0) return 12'($urandom_range(4095, th));
    return 12'($urandom_range(th - 1'b1, 0));
  endfunction

  // Enter and leave at a falling edge; valid stays high for a back-to-back beat.
  task automatic send_tick(logic [SENSE_W-1:0] ls, logic [SENSE_W-1:0] rs,
                           bit lreq, bit rreq);
    int gap;
    gap = draw_gap();
    if (flood > 0) flood--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, rreq, lreq, rs, ls};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick({6'b0, rreq, lreq, rs, ls});
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, val);
    @(negedge clk);
  endtask

  task automatic set_config(logic [CFG_DAT_W-1:0] iv, logic [CFG_DAT_W-1:0] th,
                            logic [CFG_DAT_W-1:0] ts, logic [CFG_DAT_W-1:0] ri);
    drain();
    write_reg(CFG_SAMPLE_INTERVAL, iv);
    write_reg(CFG_TRIP_THRESHOLD, th);
    write_reg(CFG_TRIP_SAMPLES, ts);
    write_reg(CFG_RECOVER_INTERVAL, ri);
    write_reg(CFG_NO_REG, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    cur_iv = iv;
    cur_th = th[SENSE_W-1:0];
    settings++;
  endtask

  // Runs of over- and under-threshold readings per channel, with some noise.
  task automatic run_random(int count);
    bit hi [2];
    int span;
    hi[0] = 0;
    hi[1] = 0;
    span = (cur_iv > 50) ? 50 : int'(cur_iv);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == 20) begin
        hold_off_req = 1;
        flood = 100;
      end
      for (int c = 0; c < 2; c++)
        if ($urandom_range(0, 6 * (span + 1)) == 0) hi[c] = !hi[c];
      send_tick(draw_level(hi[0], cur_th), draw_level(hi[1], cur_th),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (hold_off_req) begin
        hold_off_req = 0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [SENSE_W-1:0] fast_left [13] = '{12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000,
                                           12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                                           12'h000, 12'h000, 12'h000};
    logic [SENSE_W-1:0] ls;
    logic [CFG_DAT_W-1:0] iv, ri;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: extremes of the readings, every request pair
    for (int i = 0; i < 12; i++) begin
      ls = i[0] ? 12'hFFF : 12'h000;
      send_tick(ls, ~ls, i[1], i[2]);
    end

    // zero interval, zero trip count, zero recovery, top threshold
    set_config(16'd0, 16'hFFFF, 16'h0F00, 16'd0);
    foreach (fast_left[i]) send_tick(fast_left[i], 12'h000, 1'b1, i[0]);

    set_config(16'd0, {4'($urandom), 12'($urandom_range(1, 4095))}, 16'd1, 16'd0);
    run_random(250);
    set_config(16'hFFFF, 16'd0, 16'hFF, 16'hFFFF);
    run_random(40);
    set_config(16'd0, 16'hF000, 16'd255, 16'd5);
    run_random(500);
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 3))
        0: iv = 16'd0;
        1: iv = 16'd1;
        2: iv = 16'($urandom_range(2, 6));
        default: iv = 16'($urandom_range(7, 40));
      endcase
      ri = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 60));
      set_config(iv, {4'($urandom), 12'($urandom_range(0, 4095))},
                 {8'($urandom), 8'($urandom_range(0, 5))}, ri);
      run_random(170);
    end

    // long trip on the left: the fault holds through several low samples before it clears
    set_config(16'd3, 16'd2048, 16'd1, 16'd40);
    no_idle = 1;
    for (int i = 0; i < 80; i++)
      send_tick((i < 20) ? 12'($urandom_range(2048, 4095)) : 12'($urandom_range(0, 2047)),
                12'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));

    drain();
    $display("covered %0d ticks over %0d register settings (%0d writes), %0d samples",
             sb.ticks, settings + 1, sb.writes, sb.samples);
    $display("channels tripped %0d times and recovered %0d times, %0d mismatches",
             sb.trips, sb.clears, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dual_load_switch_overcurrent_guard regression: pass");
    end else begin
      $display("dual_load_switch_overcurrent_guard regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dlsog_pkg.sv
src/dlsog_chan.sv
src/dlsog_out.sv
src/dual_load_switch_overcurrent_guard.sv
tb/tb_dual_load_switch_overcurrent_guard.sv
